FILE: sv/timer_bank_with_reload_assert.svh
// Assertion macros shared by the timer bank RTL.
// Each macro checks one implication on the rising clock edge, with reset masking.
`ifndef TIMER_BANK_WITH_RELOAD_ASSERT_SVH
`define TIMER_BANK_WITH_RELOAD_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TBR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer bank: same-cycle check failed");

// Next-cycle implication.
`define TBR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer bank: next-cycle check failed");

`else

`define TBR_ASSERT_IMPL(label, ante, cons)
`define TBR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/tbr_pkg.sv
package tbr_pkg;

	// Bank geometry.
	localparam int NUM_TIMERS  = 16;
	localparam int PERIOD_BITS = 16;
	localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int FREE_CNT_W  = $clog2(NUM_TIMERS + 1);

	// Fixed field widths of the item and result transfers.
	localparam int OPCODE_W  = 3;
	localparam int SLOT_W    = 4;
	localparam int TICKS_W   = 16;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int VALUE_W   = 16;
	localparam int ELAPSED_W = 13;
	localparam int FREE_W    = 5;

	// Divide by ten: (x * 52429) >> 19 is exact for every 16-bit x.
	localparam int                     RECIP_SHIFT = 19;
	localparam logic [VALUE_W-1:0]     RECIP_TEN   = 16'd52429;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_START   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_RESUME  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_STOP    = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_REL_ALL = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_QUERY   = 3'd7;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd2;

	// State of one timer slot, as held by one cell of the ring.
	typedef struct packed {
		logic                   used;
		logic                   running;
		logic                   reload;
		logic [PERIOD_BITS-1:0] period;
		logic [PERIOD_BITS-1:0] count;
	} slot_rec_t;

	// What the head unit saw while updating the slot under it.
	typedef struct packed {
		logic expire;
		logic take;
		logic match;
	} head_evt_t;

	// Index of the single set bit of a one-hot vector.
	function automatic logic [IDX_W-1:0] onehot_index(input logic [NUM_TIMERS-1:0] oh);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (oh[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: sv/tbr_cell.sv
module tbr_cell
	import tbr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  slot_rec_t d,
	output slot_rec_t q
);

	logic                   used_q;
	logic                   running_q;
	logic                   reload_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] count_q;

	// Slot flags are control state and clear on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			running_q <= 1'b0;
			reload_q  <= 1'b0;
		end else if (shift) begin
			used_q    <= d.used;
			running_q <= d.running;
			reload_q  <= d.reload;
		end
	end

	// Period and count are undefined until written.
	always_ff @(posedge clk) begin
		if (shift) begin
			period_q <= d.period;
			count_q  <= d.count;
		end
	end

	assign q = '{used: used_q, running: running_q, reload: reload_q,
		period: period_q, count: count_q};

endmodule

FILE: sv/tbr_head.sv
module tbr_head
	import tbr_pkg::*;
(
	input  slot_rec_t              rec,
	input  logic [OPCODE_W-1:0]    opcode,
	input  logic [SLOT_W-1:0]      slot,
	input  logic [PERIOD_BITS-1:0] period,
	input  logic                   fire_once,
	input  logic [IDX_W-1:0]       step,
	input  logic                   create_done,
	output slot_rec_t              rec_next,
	output head_evt_t              evt
);

	logic [PERIOD_BITS-1:0] count_dec;

	assign count_dec = rec.count - PERIOD_BITS'(1);

	// Apply the current command to the slot that sits at the head of the ring.
	always_comb begin
		rec_next   = rec;
		evt.expire = 1'b0;
		evt.take   = 1'b0;
		evt.match  = (32'(step) == 32'(slot)) && (32'(slot) < NUM_TIMERS);

		unique case (opcode) inside
			OP_TICK: begin
				if (rec.running) begin
					rec_next.count = count_dec;
					if (count_dec == '0) begin
						evt.expire = 1'b1;
						if (rec.reload) begin
							rec_next.count = rec.period;
						end else begin
							rec_next.running = 1'b0;
							rec_next.used    = 1'b0;
						end
					end
				end
			end
			OP_CREATE: begin
				if ((period != '0) && !create_done && !rec.used) begin
					evt.take         = 1'b1;
					rec_next.used    = 1'b1;
					rec_next.running = 1'b0;
					rec_next.period  = period;
					rec_next.reload  = !fire_once;
				end
			end
			OP_START, OP_RESUME, OP_STOP, OP_RELEASE: begin
				if (evt.match && rec.used) begin
					if (opcode == OP_START) begin
						rec_next.count   = rec.period;
						rec_next.running = 1'b1;
					end else if (opcode == OP_RESUME) begin
						rec_next.running = 1'b1;
					end else if (opcode == OP_STOP) begin
						rec_next.running = 1'b0;
					end else begin
						rec_next.running = 1'b0;
						rec_next.used    = 1'b0;
					end
				end
			end
			OP_REL_ALL: begin
				rec_next.running = 1'b0;
				rec_next.used    = 1'b0;
			end
			default: begin
				// Query leaves the slot as it is.
			end
		endcase
	end

endmodule

FILE: sv/timer_bank_with_reload.sv
// Bank of NUM_TIMERS countdown timers driven by one command stream. Each slot lives in one
// cell of a ring; during a pass, the ring turns one cell per clock and a
// single head unit updates the slot passing through it. An item is taken in, then the ring
// makes one full turn, the elapsed-time arithmetic runs in S_FIN1 and S_FIN2, and then the
// results are loaded into the output register one at a time, held back while the receiver
// stalls. The next item is taken in the cycle after the last result has been loaded into
// the output register.
// A tick gives one result per expiry and none if it has none; every other command gives
// exactly one, and free_slots in each result is the count after the whole command has been applied.
module timer_bank_with_reload
	import tbr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [TICKS_W-1:0]    period_ticks,
	input  logic                  fire_once,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     kind,
	output logic [SLOT_W-1:0]     slot_out,
	output logic [STATUS_W-1:0]   status,
	output logic [VALUE_W-1:0]    count_now,
	output logic [VALUE_W-1:0]    period_now,
	output logic [ELAPSED_W-1:0]  elapsed,
	output logic                  is_running,
	output logic [FREE_W-1:0]     free_slots,
	output logic                  last
);

`include "timer_bank_with_reload_assert.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RUN  = 3'd1;
	localparam logic [2:0] S_FIN1 = 3'd2;
	localparam logic [2:0] S_FIN2 = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_TIMERS - 1);

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       step_q;
	logic [OPCODE_W-1:0]    op_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [PERIOD_BITS-1:0] per_q;
	logic                   fire_once_q;
	logic                   create_done_q;
	logic [IDX_W-1:0]       found_q;
	logic [FREE_CNT_W-1:0]  free_cnt_q;
	logic [NUM_TIMERS-1:0]  exp_mask_q;
	logic                   cap_used_q;
	logic                   cap_running_q;
	logic [PERIOD_BITS-1:0] cap_count_q;
	logic [PERIOD_BITS-1:0] cap_period_q;
	logic [PERIOD_BITS-1:0] diff_q;
	logic [ELAPSED_W-1:0]   elapsed_q;

	logic                   accept;
	logic                   run;
	logic                   out_load;
	slot_rec_t              cell_q [NUM_TIMERS];
	slot_rec_t              head_next;
	head_evt_t              evt;
	logic [NUM_TIMERS-1:0]  low_oh;
	logic [NUM_TIMERS-1:0]  mask_rest;
	logic [2*VALUE_W-1:0]   prod;

	logic [KIND_W-1:0]      res_kind;
	logic [SLOT_W-1:0]      res_slot;
	logic [STATUS_W-1:0]    res_status;
	logic [VALUE_W-1:0]     res_count;
	logic [VALUE_W-1:0]     res_period;
	logic [ELAPSED_W-1:0]   res_elapsed;
	logic                   res_running;
	logic                   res_last;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign run      = (state_q == S_RUN);
	assign out_load = (state_q == S_EMIT) && (!out_valid || !out_stall);

	// Ring of slot cells; the head's updated record enters at the tail.
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ring
		slot_rec_t cell_d;
		if (i == NUM_TIMERS - 1) begin : g_tail
			assign cell_d = head_next;
		end else begin : g_mid
			assign cell_d = cell_q[i+1];
		end
		tbr_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (run),
			.d     (cell_d),
			.q     (cell_q[i])
		);
	end

	// Update unit at the head of the ring.
	tbr_head u_head (
		.rec        (cell_q[0]),
		.opcode     (op_q),
		.slot       (slot_q),
		.period     (per_q),
		.fire_once  (fire_once_q),
		.step       (step_q),
		.create_done(create_done_q),
		.rec_next   (head_next),
		.evt        (evt)
	);

	// Command capture and per-pass bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= '0;
			create_done_q <= 1'b0;
			free_cnt_q    <= '0;
			exp_mask_q    <= '0;
			cap_used_q    <= 1'b0;
			cap_running_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q       <= S_RUN;
						step_q        <= '0;
						create_done_q <= 1'b0;
						free_cnt_q    <= '0;
						exp_mask_q    <= '0;
						cap_used_q    <= 1'b0;
						cap_running_q <= 1'b0;
					end
				end
				S_RUN: begin
					if (!head_next.used) begin
						free_cnt_q <= free_cnt_q + FREE_CNT_W'(1);
					end
					if (evt.expire) begin
						exp_mask_q[step_q] <= 1'b1;
					end
					if (evt.take) begin
						create_done_q <= 1'b1;
					end
					if (evt.match) begin
						cap_used_q    <= cell_q[0].used;
						cap_running_q <= cell_q[0].running;
					end
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= S_FIN1;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if ((op_q == OP_TICK) && (exp_mask_q == '0)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						if (op_q == OP_TICK) begin
							exp_mask_q <= mask_rest;
							if (mask_rest == '0) begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item fields, created slot and queried slot values.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= opcode;
			slot_q      <= slot;
			per_q       <= PERIOD_BITS'(period_ticks);
			fire_once_q <= fire_once;
		end
		if (run && evt.take) begin
			found_q <= step_q;
		end
		if (run && evt.match) begin
			cap_count_q  <= cell_q[0].count;
			cap_period_q <= cell_q[0].period;
		end
	end

	// Elapsed time: subtract in S_FIN1, then divide by ten by reciprocal in S_FIN2.
	assign prod = (2*VALUE_W)'(diff_q) * (2*VALUE_W)'(RECIP_TEN);

	always_ff @(posedge clk) begin
		if (state_q == S_FIN1) begin
			diff_q <= (cap_count_q > cap_period_q) ? '0 : (cap_period_q - cap_count_q);
		end
		if (state_q == S_FIN2) begin
			elapsed_q <= prod[RECIP_SHIFT +: ELAPSED_W];
		end
	end

	// Lowest pending expiry, reported first.
	assign low_oh    = exp_mask_q & ((~exp_mask_q) + NUM_TIMERS'(1));
	assign mask_rest = exp_mask_q & ~low_oh;

	// Result contents for the command just finished.
	always_comb begin
		res_kind    = KIND_REPLY;
		res_slot    = slot_q;
		res_status  = cap_used_q ? ST_OK : ST_UNUSED;
		res_count   = '0;
		res_period  = '0;
		res_elapsed = '0;
		res_running = 1'b0;
		res_last    = 1'b1;
		unique case (op_q) inside
			OP_TICK: begin
				res_kind   = KIND_EXPIRY;
				res_slot   = SLOT_W'(onehot_index(low_oh));
				res_status = ST_OK;
				res_last   = (mask_rest == '0);
			end
			OP_CREATE: begin
				res_slot   = create_done_q ? SLOT_W'(found_q) : '0;
				res_status = create_done_q ? ST_OK : ST_NO_SLOT;
			end
			OP_REL_ALL: begin
				res_slot   = '0;
				res_status = ST_OK;
			end
			OP_QUERY: begin
				res_kind    = KIND_QUERY;
				res_running = cap_running_q;
				if (cap_used_q) begin
					res_count   = VALUE_W'(cap_count_q);
					res_period  = VALUE_W'(cap_period_q);
					res_elapsed = elapsed_q;
				end
			end
			OP_START, OP_RESUME, OP_STOP, OP_RELEASE: begin
				res_status = cap_used_q ? ST_OK : ST_UNUSED;
			end
			default: begin
				res_last = 1'b1;
			end
		endcase
	end

	// Output register; a waiting result holds until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind       <= res_kind;
			slot_out   <= res_slot;
			status     <= res_status;
			count_now  <= res_count;
			period_now <= res_period;
			elapsed    <= res_elapsed;
			is_running <= res_running;
			free_slots <= FREE_W'(free_cnt_q);
			last       <= res_last;
		end
	end

	// A pass over the ring always ends after exactly one full turn.
	`TBR_ASSERT_NEXT(a_pass_end, run && (step_q == LAST_STEP), (state_q == S_FIN1) && (step_q == '0))
	// Create never takes a second slot in the same pass.
	`TBR_ASSERT_IMPL(a_one_take, run && evt.take, !create_done_q)
	// A tick only reaches the result stage with an expiry pending.
	`TBR_ASSERT_IMPL(a_tick_emit, (state_q == S_EMIT) && (op_q == OP_TICK), exp_mask_q != '0)
	// The free count never exceeds the bank size once a pass is done.
	`TBR_ASSERT_IMPL(a_free_range, state_q == S_EMIT, 32'(free_cnt_q) <= NUM_TIMERS)

endmodule
